FILE: rtl/lzwe_pkg.sv
// Package: constants, payload types and the dictionary entry layout of the LZW encoder.
`timescale 1ns / 1ps
package lzwe_pkg;

  localparam int LAST_CODE  = 32767;
  localparam int CODE_W     = $clog2(LAST_CODE + 1);
  localparam int FREE_W     = CODE_W + 1;
  localparam int SLOT_W     = CODE_W + 1;
  localparam int KEY_W      = CODE_W + 8;
  localparam int TAG_W      = 8;
  localparam int WIDTH_W    = 5;
  localparam int COUNT_W    = 17;
  localparam int BUMP_W     = 18;
  localparam int BUF_W      = 24;
  localparam int BITS_W     = 5;

  localparam logic [CODE_W-1:0]  END_CODE   = CODE_W'(256);
  localparam logic [FREE_W-1:0]  FIRST_FREE = FREE_W'(257);
  localparam logic [WIDTH_W-1:0] FIRST_WIDTH = WIDTH_W'(9);
  localparam logic [COUNT_W-1:0] FIRST_COUNT = COUNT_W'(256);
  localparam logic [BUMP_W-1:0]  FIRST_BUMP  = BUMP_W'(512);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              fin;
  } code_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } dict_ent_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_MISS,
    ST_FIN,
    ST_END
  } eng_state_t;

endpackage

FILE: rtl/lzwe_packer.sv
// Bit packer: takes codes at the current width and sends them out LSB-first as bytes.
`timescale 1ns / 1ps
module lzwe_packer (
  input  logic              clk,
  input  logic              rst,
  input  logic              code_valid,
  output logic              code_ready,
  input  lzwe_pkg::code_req_t code_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lzwe_pkg::out_t    out_data
);
  import lzwe_pkg::*;

  logic [BUF_W-1:0]   bitbuf, bitbuf_next;
  logic [BITS_W-1:0]  nbits, nbits_next;
  logic [WIDTH_W-1:0] width, width_next;
  logic [COUNT_W-1:0] emitted, emitted_next;
  logic [BUMP_W-1:0]  bump, bump_next;
  logic               busy, busy_next;
  logic               fin, fin_next;
  logic               ovalid, ovalid_next;
  out_t               obuf, obuf_next;
  logic               can_load;
  logic [16:0]        mask;
  logic [16:0]        code_m;
  logic [COUNT_W-1:0] emitted_inc;

  assign code_ready = !busy;
  assign can_load   = !ovalid || out_ready;
  assign out_valid  = ovalid;
  assign out_data   = obuf;
  assign mask       = 17'((18'd1 << width) - 18'd1);
  assign code_m     = 17'(code_data.code) & mask;
  assign emitted_inc = emitted + COUNT_W'(1);

  always_comb begin
    bitbuf_next  = bitbuf;
    nbits_next   = nbits;
    width_next   = width;
    emitted_next = emitted;
    bump_next    = bump;
    busy_next    = busy;
    fin_next     = fin;
    ovalid_next  = ovalid && !out_ready;
    obuf_next    = obuf;
    if (!busy) begin
      if (code_valid) begin
        bitbuf_next = bitbuf | (BUF_W'(code_m) << nbits);
        nbits_next  = nbits + BITS_W'(width);
        busy_next   = 1'b1;
        fin_next    = code_data.fin;
        if (code_data.fin) begin
          width_next   = FIRST_WIDTH;
          emitted_next = FIRST_COUNT;
          bump_next    = FIRST_BUMP;
        end else if (emitted < COUNT_W'(LAST_CODE)) begin
          emitted_next = emitted_inc;
          if (BUMP_W'(emitted_inc) == bump) begin
            bump_next  = bump << 1;
            width_next = width + WIDTH_W'(1);
          end
        end
      end
    end else if (can_load) begin
      if (nbits >= BITS_W'(8)) begin
        ovalid_next       = 1'b1;
        obuf_next.out_byte = bitbuf[7:0];
        obuf_next.out_last = fin && (nbits == BITS_W'(8));
        bitbuf_next       = bitbuf >> 8;
        nbits_next        = nbits - BITS_W'(8);
      end else begin
        // flush the leftover bits only at end of stream, and only if there are any
        if (fin && nbits != '0) begin
          ovalid_next        = 1'b1;
          obuf_next.out_byte = bitbuf[7:0];
          obuf_next.out_last = 1'b1;
        end
        if (fin) begin
          bitbuf_next = '0;
          nbits_next  = '0;
        end
        busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitbuf  <= '0;
      nbits   <= '0;
      width   <= FIRST_WIDTH;
      emitted <= FIRST_COUNT;
      bump    <= FIRST_BUMP;
      busy    <= 1'b0;
      fin     <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      bitbuf  <= bitbuf_next;
      nbits   <= nbits_next;
      width   <= width_next;
      emitted <= emitted_next;
      bump    <= bump_next;
      busy    <= busy_next;
      fin     <= fin_next;
      ovalid  <= ovalid_next;
    end
    obuf <= obuf_next;
  end

endmodule

FILE: rtl/lzw_encoder_variable_width.sv
// Top level of the LZW encoder: dictionary hash table, probe control and packer hookup.
// Flow: the first byte of a stream only starts the prefix; a continuing byte is accepted and
//   probed, once more per hash collision; a miss then hands its code to the packer, as do the last codes.
// The packer holds a code while it sends out its bytes; a new code waits while it is busy.
// Reset: synchronous, then a clearing pass over all 2**SLOT_W slots (65536 at LAST_CODE 32767)
//   before the first request; the pass repeats after every 255th stream when the tag wraps.
`timescale 1ns / 1ps
module lzw_encoder_variable_width (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzwe_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lzwe_pkg::out_t out_data
);
  import lzwe_pkg::*;

  // Hash table: slot holds stream tag, (prefix, byte) key and its code.
  dict_ent_t mem [2**SLOT_W];
  dict_ent_t rdata;
  dict_ent_t wdata;
  logic [SLOT_W-1:0] raddr, waddr;
  logic              we;

  eng_state_t        state, state_next;
  logic [CODE_W-1:0] prefix, prefix_next;
  logic              prefix_valid, prefix_valid_next;
  logic [FREE_W-1:0] next_free, next_free_next;
  logic [TAG_W-1:0]  epoch, epoch_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [SLOT_W-1:0] clr_addr, clr_addr_next;
  logic [7:0]        byte_r, byte_r_next;
  logic              last_r, last_r_next;

  logic              code_valid, code_ready;
  code_req_t         code_data;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] hash;
  logic              hit, empty;

  assign key_r = {prefix, byte_r};
  // fold the byte into the top of the slot index
  assign hash  = SLOT_W'(prefix) ^ {in_data.in_byte, {(SLOT_W-8){1'b0}}};
  assign hit   = (rdata.tag == epoch) && (rdata.key == key_r);
  assign empty = (rdata.tag != epoch);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Next state and register updates.
  always_comb begin
    state_next        = state;
    prefix_next       = prefix;
    prefix_valid_next = prefix_valid;
    next_free_next    = next_free;
    epoch_next        = epoch;
    slot_next         = slot;
    clr_addr_next     = clr_addr;
    byte_r_next       = byte_r;
    last_r_next       = last_r;
    case (state)
      ST_CLEAR: begin
        clr_addr_next = clr_addr + SLOT_W'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          byte_r_next = in_data.in_byte;
          last_r_next = in_data.in_last;
          if (!prefix_valid) begin
            // first byte of a stream just starts the prefix
            prefix_next       = CODE_W'(in_data.in_byte);
            prefix_valid_next = 1'b1;
            state_next        = in_data.in_last ? ST_FIN : ST_IDLE;
          end else begin
            slot_next  = hash;
            state_next = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (hit) begin
          prefix_next = rdata.code;
          state_next  = last_r ? ST_FIN : ST_IDLE;
        end else if (empty) begin
          if (next_free <= FREE_W'(LAST_CODE)) begin
            next_free_next = next_free + FREE_W'(1);
          end
          state_next = ST_MISS;
        end else begin
          slot_next = slot + SLOT_W'(1);
        end
      end
      ST_MISS: begin
        if (code_ready) begin
          prefix_next = CODE_W'(byte_r);
          state_next  = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (code_ready) begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (code_ready) begin
          // drop the stream: fresh tag, or a clearing pass once the tag wraps
          prefix_valid_next = 1'b0;
          next_free_next    = FIRST_FREE;
          if (epoch == '1) begin
            epoch_next    = TAG_W'(1);
            clr_addr_next = '0;
            state_next    = ST_CLEAR;
          end else begin
            epoch_next = epoch + TAG_W'(1);
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake, table ports and code requests.
  always_comb begin
    in_ready   = 1'b0;
    raddr      = slot + SLOT_W'(1);
    we         = 1'b0;
    waddr      = slot;
    wdata      = '{tag: epoch, key: key_r, code: next_free[CODE_W-1:0]};
    code_valid = 1'b0;
    code_data  = '{code: prefix, fin: 1'b0};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        raddr    = hash;
      end
      ST_PROBE: begin
        we = empty && (next_free <= FREE_W'(LAST_CODE));
      end
      ST_MISS: begin
        code_valid = 1'b1;
      end
      ST_FIN: begin
        code_valid = 1'b1;
      end
      ST_END: begin
        code_valid = 1'b1;
        code_data  = '{code: END_CODE, fin: 1'b1};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      prefix_valid <= 1'b0;
      next_free    <= FIRST_FREE;
      epoch        <= TAG_W'(1);
      clr_addr     <= '0;
      prefix       <= '0;
    end else begin
      state        <= state_next;
      prefix_valid <= prefix_valid_next;
      next_free    <= next_free_next;
      epoch        <= epoch_next;
      clr_addr     <= clr_addr_next;
      prefix       <= prefix_next;
    end
    slot   <= slot_next;
    byte_r <= byte_r_next;
    last_r <= last_r_next;
  end

  lzwe_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code_data  (code_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: tb/lzw_encoder_variable_width_test.sv
// Self-checking testbench for the variable-width LZW encoder.
`timescale 1ns / 1ps
module lzw_encoder_variable_width_test;
  import lzwe_pkg::*;

  // Idle cycles allowed before the run is called hung: covers the clearing pass after reset
  // and after tag wrap, plus the longest sender gap and receiver stall.
  localparam int IDLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  lzw_encoder_variable_width u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be sent, and packed bytes the encoder should produce.
  in_t  byte_q[$];
  out_t packed_q[$];
  int   err_count = 0;

  // Shadow encoder state for the current stream.
  int   dict_code[int];
  int   next_free;
  int   prefix;
  bit   prefix_ok;
  int   bit_buf;
  int   bit_cnt;
  int   code_w;
  int   emit_cnt;
  int   bump_at;

  task automatic start_stream();
    dict_code.delete();
    next_free = 257;
    prefix    = 0;
    prefix_ok = 1'b0;
    bit_buf   = 0;
    bit_cnt   = 0;
    code_w    = 9;
    emit_cnt  = 256;
    bump_at   = 512;
  endtask

  task automatic push_byte(int b, bit lst);
    out_t o;
    o.out_byte = b[7:0];
    o.out_last = lst;
    packed_q.push_back(o);
  endtask

  // Append one code to the bit stream, then grow the width when the count hits the bump.
  task automatic pack_code(int code);
    bit_buf = bit_buf | ((code & ((1 << code_w) - 1)) << bit_cnt);
    bit_cnt += code_w;
    while (bit_cnt >= 8) begin
      push_byte(bit_buf & 8'hff, 1'b0);
      bit_buf = bit_buf >> 8;
      bit_cnt -= 8;
    end
    bit_buf &= 24'hffffff;
    if (emit_cnt < LAST_CODE) begin
      emit_cnt++;
      if (emit_cnt == bump_at) begin
        bump_at *= 2;
        code_w++;
      end
    end
  endtask

  task automatic encode_byte(in_t it);
    int key;
    int b;
    b = it.in_byte;
    if (!prefix_ok) begin
      prefix    = b;
      prefix_ok = 1'b1;
    end else begin
      key = ((prefix & 16'hffff) << 8) | b;
      if (dict_code.exists(key)) begin
        prefix = dict_code[key];
      end else begin
        // Learn the pair only while codes remain.
        if (next_free <= LAST_CODE) begin
          dict_code[key] = next_free;
          next_free++;
        end
        pack_code(prefix);
        prefix = b;
      end
    end
    if (it.in_last) begin
      pack_code(prefix);
      pack_code(int'(END_CODE));
      // Flush leftover bits only when the stream is not byte aligned.
      if (bit_cnt > 0) push_byte(bit_buf & 8'hff, 1'b0);
      packed_q[packed_q.size()-1].out_last = 1'b1;
      start_stream();
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic add_stream(int len, int hi);
    in_t it;
    for (int i = 0; i < len; i++) begin
      it.in_byte = 8'($urandom_range(0, hi));
      it.in_last = (i == len - 1);
      byte_q.push_back(it);
    end
  endtask

  task automatic add_fixed(int b, bit lst);
    in_t it;
    it.in_byte = b[7:0];
    it.in_last = lst;
    byte_q.push_back(it);
  endtask

  // Monitor: predict on each accepted request, check each accepted output byte.
  int   idle_cycles = 0;
  int   in_count = 0;
  out_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
        in_count++;
      end
      if (out_valid && out_ready) begin
        if (packed_q.size() == 0) begin
          report_mismatch("unexpected byte", out_data.out_byte, 0);
        end else begin
          want = packed_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.out_last !== want.out_last)
            report_mismatch("out_last", out_data.out_last, want.out_last);
        end
      end
      // Watchdog: count only cycles where neither side moves anything.
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  int in_seen = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_count != in_seen)) begin
      in_seen = in_count;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_data  <= byte_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternate between free-flowing stretches and stretches of random stalls.
  int stall_phase = 0;
  bit stall_mode = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(5, 60);
        stall_mode  = 1'($urandom_range(0, 1));
      end else begin
        stall_phase--;
      end
      out_ready <= stall_mode ? ($urandom_range(0, 3) != 0 ? 1'b0 : 1'b1) : 1'b1;
    end
  end

  initial begin
    start_stream();
    // Directed: single-byte streams at the byte extremes, hits on a run of one byte,
    // a stream that ends byte aligned, and back-to-back streams.
    add_fixed(8'h00, 1'b1);
    add_fixed(8'hff, 1'b1);
    for (int i = 0; i < 10; i++) add_fixed(8'h61, i == 9);
    for (int i = 0; i < 7; i++) add_fixed(8'h30 + i, i == 6);
    add_fixed(8'h55, 1'b0);
    add_fixed(8'haa, 1'b1);
    // One long full-range stream drives the code count past the first width bump.
    add_stream(300, 255);
    // Short streams on narrow alphabets for dictionary hits, some on the full range.
    while (byte_q.size() < 380) begin
      if ($urandom_range(0, 3) == 0) add_stream($urandom_range(1, 12), 255);
      else add_stream($urandom_range(2, 30), $urandom_range(1, 4));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (byte_q.size() == 0 && !in_valid);
    wait (packed_q.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0 && packed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
